/* hdl/largest_empty_square_scan_defines.svh */
// Assertion helpers shared by the scan blocks.
// Both expect clk_i and rst_ni in scope.
`ifndef LARGEST_EMPTY_SQUARE_SCAN_DEFINES_SVH
`define LARGEST_EMPTY_SQUARE_SCAN_DEFINES_SVH

// Property checked at every edge outside reset
`define LESQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent this cycle, consequent the next
`define LESQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lesq_pkg.sv */
package lesq_pkg;

  // Geometry
  localparam int MaxWidth = 1024;
  localparam int MaxRows  = 1024;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int RowW     = $clog2(MaxRows);
  localparam int WidthW   = ColW + 1;
  localparam int SizeW    = 11;
  localparam int CharW    = 8;

  localparam logic [CharW-1:0]  ObstacleChar = 8'h6F;
  localparam logic [SizeW-1:0]  SizeMax      = '1;
  localparam logic [WidthW-1:0] WidthReset   = WidthW'(MaxWidth);
  localparam logic [WidthW-1:0] WidthMax     = WidthW'(MaxWidth);
  localparam logic [RowW-1:0]   RowLast      = RowW'(MaxRows - 1);

  // Request moved from the counter stage to the size stage
  typedef struct packed {
    logic             obstacle;
    logic             last;
    logic             row_end;
    logic             row_zero;
    logic [ColW-1:0]  col;
    logic [RowW-1:0]  row;
    logic             fwd;
    logic [SizeW-1:0] fwd_data;
  } s1_t;

  // Line store write port
  typedef struct packed {
    logic             we;
    logic [ColW-1:0]  addr;
    logic [SizeW-1:0] data;
  } wr_t;

  function automatic logic [SizeW-1:0] min3(input logic [SizeW-1:0] a,
                                            input logic [SizeW-1:0] b,
                                            input logic [SizeW-1:0] c);
    logic [SizeW-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

endpackage

/* hdl/lesq_if.sv */
// Map cell request channel
interface lesq_cell_if;
  logic                       valid;
  logic                       ready;
  logic [lesq_pkg::CharW-1:0] cell_req;
  logic                       end_of_map;

  modport source (output valid, output cell_req, output end_of_map, input ready);
  modport sink   (input valid, input cell_req, input end_of_map, output ready);
endinterface

// Result channel
interface lesq_result_if;
  logic                       valid;
  logic                       ready;
  logic [lesq_pkg::SizeW-1:0] best_size;
  logic [lesq_pkg::RowW-1:0]  best_row;
  logic [lesq_pkg::ColW-1:0]  best_col;

  modport source (output valid, output best_size, output best_row, output best_col,
                  input ready);
  modport sink   (input valid, input best_size, input best_row, input best_col,
                  output ready);
endinterface

/* hdl/lesq_line_ram.sv */
module lesq_line_ram #(
  parameter int Depth = 1024,
  parameter int Width = 11,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, old data on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/lesq_scan_ctrl.sv */
`include "largest_empty_square_scan_defines.svh"

module lesq_scan_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lesq_pkg::WidthW-1:0] cfg_wdata_i,
  lesq_cell_if.sink                   cell_if,
  input  logic                        s1_fire_i,
  input  lesq_pkg::wr_t               wr_i,
  output logic                        s1_valid_o,
  output lesq_pkg::s1_t               s1_o,
  output logic                        rd_en_o,
  output logic [lesq_pkg::ColW-1:0]   rd_addr_o
);
  import lesq_pkg::*;

  logic [WidthW-1:0] width_q;
  logic [ColW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;
  logic              s1_valid_q, s1_valid_d;
  s1_t               s1_q, s1_d;
  logic [WidthW-1:0] act_width;
  logic              row_end;
  logic              accept;

  // Stage 1 frees up when it is empty or retires this cycle
  assign cell_if.ready = !s1_valid_q || s1_fire_i;
  assign accept        = cell_if.valid && cell_if.ready;

  // Line width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthReset;
    end else if (cfg_we_i) begin
      width_q <= cfg_wdata_i;
    end
  end

  // Clamp width to 1..MaxWidth
  always_comb begin
    if (width_q == '0) begin
      act_width = WidthW'(1);
    end else if (width_q > WidthMax) begin
      act_width = WidthMax;
    end else begin
      act_width = width_q;
    end
  end

  assign row_end = ({1'b0, col_q} + WidthW'(1)) >= act_width;

  // Raster position counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (cell_if.end_of_map) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end) begin
        col_d = '0;
        if (row_q < RowLast) begin
          row_d = row_q + RowW'(1);
        end
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  // Request into the size stage; forward the write that collides with this read
  always_comb begin
    s1_d.obstacle = (cell_if.cell_req == ObstacleChar);
    s1_d.last     = cell_if.end_of_map;
    s1_d.row_end  = row_end;
    s1_d.row_zero = (row_q == '0);
    s1_d.col      = col_q;
    s1_d.row      = row_q;
    s1_d.fwd      = wr_i.we && (wr_i.addr == col_q);
    s1_d.fwd_data = wr_i.data;
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;
  assign rd_en_o    = accept;
  assign rd_addr_o  = col_q;

  `LESQ_ASSERT_NEXT(a_row_monotonic, accept && !cell_if.end_of_map, row_q >= $past(row_q),
    "row index went backwards inside a map")
  `LESQ_ASSERT_NEXT(a_wrap_to_col0, accept && row_end, col_q == '0,
    "column did not wrap at row end")
  `LESQ_ASSERT_NEXT(a_col_step, accept && !row_end && !cell_if.end_of_map,
    col_q == $past(col_q) + ColW'(1), "column did not advance by one")

endmodule

/* hdl/lesq_size_calc.sv */
`include "largest_empty_square_scan_defines.svh"

module lesq_size_calc (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s1_valid_i,
  input  lesq_pkg::s1_t              s1_i,
  input  logic [lesq_pkg::SizeW-1:0] rd_data_i,
  output logic                       s1_fire_o,
  output lesq_pkg::wr_t              wr_o,
  lesq_result_if.source              res_if
);
  import lesq_pkg::*;

  logic [SizeW-1:0] left_q, left_d;
  logic [SizeW-1:0] upl_q, upl_d;
  logic [SizeW-1:0] large_q, large_d;
  logic [RowW-1:0]  lrow_q, lrow_d;
  logic [ColW-1:0]  lcol_q, lcol_d;
  logic             res_valid_q, res_valid_d;
  logic [SizeW-1:0] res_size_q;
  logic [RowW-1:0]  res_row_q;
  logic [ColW-1:0]  res_col_q;
  logic [SizeW-1:0] up;
  logic [SizeW-1:0] m;
  logic [SizeW-1:0] size;
  logic             s1_fire;
  logic             load_res;

  // Retire unless a result must go into a full, stalled output register
  assign s1_fire  = s1_valid_i && (!s1_i.last || !res_valid_q || res_if.ready);
  assign load_res = s1_fire && s1_i.last;

  // Upper neighbor, bypassing the line store on a same-entry write
  assign up = s1_i.fwd ? s1_i.fwd_data : rd_data_i;
  assign m  = min3(up, upl_q, left_q);

  // Square side ending at this cell
  always_comb begin
    if (s1_i.obstacle) begin
      size = '0;
    end else if (s1_i.row_zero || (s1_i.col == '0)) begin
      size = SizeW'(1);
    end else if (m == SizeMax) begin
      size = SizeMax;
    end else begin
      size = m + SizeW'(1);
    end
  end

  // Best square and neighbor registers
  always_comb begin
    left_d  = left_q;
    upl_d   = upl_q;
    large_d = large_q;
    lrow_d  = lrow_q;
    lcol_d  = lcol_q;
    if (s1_fire) begin
      if (size > large_q) begin
        large_d = size;
        lrow_d  = s1_i.row;
        lcol_d  = s1_i.col;
      end
      if (s1_i.last) begin
        left_d  = '0;
        upl_d   = '0;
        large_d = '0;
        lrow_d  = '0;
        lcol_d  = '0;
      end else if (s1_i.row_end) begin
        left_d = '0;
        upl_d  = '0;
      end else begin
        left_d = size;
        upl_d  = up;
      end
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (load_res) begin
      res_valid_d = 1'b1;
    end else if (res_if.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      upl_q       <= '0;
      large_q     <= '0;
      lrow_q      <= '0;
      lcol_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      left_q      <= left_d;
      upl_q       <= upl_d;
      large_q     <= large_d;
      lrow_q      <= lrow_d;
      lcol_q      <= lcol_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Result register takes the best square including this last cell
  always_ff @(posedge clk_i) begin
    if (load_res) begin
      if (size > large_q) begin
        res_size_q <= size;
        res_row_q  <= s1_i.row;
        res_col_q  <= s1_i.col;
      end else begin
        res_size_q <= large_q;
        res_row_q  <= lrow_q;
        res_col_q  <= lcol_q;
      end
    end
  end

  assign res_if.valid     = res_valid_q;
  assign res_if.best_size = res_size_q;
  assign res_if.best_row  = res_row_q;
  assign res_if.best_col  = res_col_q;

  assign s1_fire_o  = s1_fire;
  assign wr_o.we    = s1_fire;
  assign wr_o.addr  = s1_i.col;
  assign wr_o.data  = size;

  `LESQ_ASSERT(a_res_from_last, $rose(res_valid_q) |-> $past(s1_fire && s1_i.last),
    "result appeared without an end-of-map cell")
  `LESQ_ASSERT_NEXT(a_clear_on_last, s1_fire && s1_i.last,
    (large_q == '0) && (left_q == '0) && (upl_q == '0),
    "scan state not cleared after end of map")
  `LESQ_ASSERT(a_empty_nonzero, (s1_valid_i && !s1_i.obstacle) |-> (size != '0),
    "empty cell produced a zero square")

endmodule

/* hdl/largest_empty_square_scan.sv */
// Largest empty square over a streamed character map.
// cell_if carries one map character per request in raster order; 'o' marks
// an obstacle. end_of_map flags the last cell of a map. res_if returns one
// result per map: side of the first largest empty square and its
// bottom-right row and column.
// cfg_we_i/cfg_wdata_i write line_width (cells per row, 0 acts as 1, above
// 1024 acts as 1024); write it only with no map in flight.
// A result goes through the stage 1 register and then the result register
// after its end_of_map cell is taken. Throughput: one cell per cycle while
// the size stage is not held; the row store is a 1024x11 RAM read at accept
// and written as the cell retires from the size stage, the read of the next
// cell bypassing that write when both hit the same entry.
// A result waits in an output register; while it is unread, cells keep
// flowing until the next end_of_map cell reaches the size stage, which then
// holds and drops cell ready.
// Reset clears counters, best-square state and the width (to 1024); the row
// store is not cleared and needs no clearing pass.
module largest_empty_square_scan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lesq_pkg::WidthW-1:0] cfg_wdata_i,
  lesq_cell_if.sink                   cell_if,
  lesq_result_if.source               res_if
);
  import lesq_pkg::*;

  logic            s1_valid;
  s1_t             s1;
  logic            s1_fire;
  wr_t             wr;
  logic            rd_en;
  logic [ColW-1:0] rd_addr;
  logic [SizeW-1:0] rd_data;

  // Counters, width clamp and read issue
  lesq_scan_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cell_if     (cell_if),
    .s1_fire_i   (s1_fire),
    .wr_i        (wr),
    .s1_valid_o  (s1_valid),
    .s1_o        (s1),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr)
  );

  // Previous-row sizes
  lesq_line_ram #(
    .Depth (MaxWidth),
    .Width (SizeW)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Min-of-three, best tracking and result register
  lesq_size_calc u_calc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid),
    .s1_i       (s1),
    .rd_data_i  (rd_data),
    .s1_fire_o  (s1_fire),
    .wr_o       (wr),
    .res_if     (res_if)
  );

endmodule

/* tb/tb_largest_empty_square_scan.sv */
module tb_largest_empty_square_scan;
  timeunit 1ns;
  timeprecision 1ps;

  import lesq_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int RandomCells = 750;
  localparam int RandomMaps = 40;

  // One expected result: side and bottom-right corner
  typedef struct packed {
    logic [SizeW-1:0] size;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
  } square_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [WidthW-1:0] cfg_wdata_i;

  lesq_cell_if   cell_if ();
  lesq_result_if res_if ();

  largest_empty_square_scan u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cell_if    (cell_if),
    .res_if     (res_if)
  );

  always #6 clk_i = ~clk_i;

  // Square predictor state
  logic [SizeW-1:0]  prev_row_sizes [MaxWidth];
  logic [WidthW-1:0] line_width_cfg;
  logic [ColW-1:0]   scan_col;
  logic [RowW-1:0]   scan_row;
  logic [SizeW-1:0]  left_side;
  logic [SizeW-1:0]  upper_left_side;
  logic [SizeW-1:0]  top_size;
  logic [RowW-1:0]   top_row;
  logic [ColW-1:0]   top_col;

  square_t expected_squares [$];
  square_t oldest_square;

  int  mismatch_cnt = 0;
  int  cycle_cnt = 0;
  int  stall_left = 0;
  // no new gaps on either side while set
  bit  steady_flow = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [CharW-1:0] empty_char();
    logic [CharW-1:0] c;
    c = CharW'($urandom_range(0, 255));
    if (c == ObstacleChar) c = c ^ 8'h01;
    return c;
  endfunction

  function automatic int active_width(input int w);
    if (w == 0) return 1;
    if (w > MaxWidth) return MaxWidth;
    return w;
  endfunction

  task automatic clear_scan();
    scan_col = '0;
    scan_row = '0;
    left_side = '0;
    upper_left_side = '0;
    top_size = '0;
    top_row = '0;
    top_col = '0;
  endtask

  // Advance the predictor by one accepted cell
  task automatic predict_square(input logic [CharW-1:0] ch, input logic last);
    int col;
    int up;
    int side;
    int m;
    col = int'(scan_col);
    up = int'(prev_row_sizes[col]);
    if (ch == ObstacleChar) begin
      side = 0;
    end else if (scan_row == '0 || col == 0) begin
      side = 1;
    end else begin
      m = up;
      if (int'(upper_left_side) < m) m = int'(upper_left_side);
      if (int'(left_side) < m) m = int'(left_side);
      side = (m + 1 > int'(SizeMax)) ? int'(SizeMax) : m + 1;
    end

    // strictly larger only, so ties keep the earlier square
    if (side > int'(top_size)) begin
      top_size = SizeW'(side);
      top_row = scan_row;
      top_col = ColW'(col);
    end

    prev_row_sizes[col] = SizeW'(side);
    upper_left_side = SizeW'(up);
    left_side = SizeW'(side);

    if (col + 1 >= active_width(int'(line_width_cfg))) begin
      scan_col = '0;
      left_side = '0;
      upper_left_side = '0;
      if (scan_row < RowLast) scan_row = scan_row + 1'b1;
    end else begin
      scan_col = ColW'(col + 1);
    end

    if (last) begin
      expected_squares.push_back('{size: top_size, row: top_row, col: top_col});
      clear_scan();
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%t: %s", $realtime, msg);
  endtask

  // Send one cell request and wait for it to be taken
  task automatic send_cell(input logic [CharW-1:0] ch, input logic last);
    int gap;
    gap = steady_flow ? 0 : pick_gap();
    if (gap > 0) begin
      cell_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cell_if.valid <= 1'b1;
    cell_if.cell_req <= ch;
    cell_if.end_of_map <= last;
    do @(posedge clk_i); while (!cell_if.ready);
    predict_square(ch, last);
  endtask

  // Map from text, '.' empty and 'o' obstacle; last char ends the map
  task automatic send_text(input string cells);
    int i;
    for (i = 0; i < cells.len(); i++) begin
      send_cell(CharW'(cells[i]), i == cells.len() - 1);
    end
  endtask

  task automatic send_random_map(input int cells, input int obstacle_pct);
    int i;
    logic [CharW-1:0] ch;
    for (i = 0; i < cells; i++) begin
      ch = ($urandom_range(0, 99) < obstacle_pct) ? ObstacleChar : empty_char();
      send_cell(ch, i == cells - 1);
    end
  endtask

  // Drop valid and let every map drain before touching the register
  task automatic wait_idle();
    cell_if.valid <= 1'b0;
    while (expected_squares.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_width(input int w);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= WidthW'(w);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    line_width_cfg = WidthW'(w);
  endtask

  // Width left at its reset value, map ends inside the first row
  task automatic test_default_width();
    send_text("..o");
  endtask

  task automatic test_no_square();
    set_width(2);
    send_text("oooo");
  endtask

  // Two squares of side 2: the first one is kept
  task automatic test_ties();
    set_width(5);
    send_text("..o....o..");
  endtask

  // Zero acts as one, above the maximum acts as the maximum
  task automatic test_width_limits();
    set_width(0);
    send_text("...");
    set_width(2047);
    send_text(".o.");
  endtask

  task automatic test_char_extremes();
    set_width(3);
    send_cell(8'h00, 1'b0);
    send_cell(8'hFF, 1'b0);
    send_cell(8'h6E, 1'b0);
    send_cell(8'h70, 1'b0);
    send_cell(ObstacleChar, 1'b0);
    send_cell(8'h20, 1'b1);
  endtask

  // Row counter saturates; the square found past it still grows
  task automatic test_tall_map();
    int r;
    int c;
    set_width(2);
    for (r = 0; r < MaxRows + 4; r++) begin
      for (c = 0; c < 2; c++) begin
        send_cell((r < MaxRows + 2) ? ObstacleChar : empty_char(),
                  r == MaxRows + 3 && c == 1);
      end
    end
  endtask

  // Full-width rows hit the last line store entry
  task automatic test_full_width();
    set_width(MaxWidth);
    send_random_map(2 * MaxWidth + 5, 10);
  endtask

  task automatic test_random_maps();
    int sent;
    int maps;
    int w;
    int pick;
    int cells;
    int pct;
    sent = 0;
    maps = 0;
    w = int'(line_width_cfg);
    while (sent < RandomCells || maps < RandomMaps) begin
      if (maps % 4 == 0) begin
        pick = $urandom_range(0, 19);
        case (pick)
          0: w = 0;
          1: w = MaxWidth;
          2: w = 2047;
          3: w = MaxWidth + 1;
          4, 5: w = $urandom_range(11, 64);
          default: w = $urandom_range(1, 10);
        endcase
        set_width(w);
      end
      cells = active_width(w) * $urandom_range(1, 6);
      if (cells > 60 || $urandom_range(0, 3) == 0) begin
        cells = $urandom_range(1, (cells > 60) ? 60 : cells);
      end
      case ($urandom_range(0, 5))
        0: pct = 0;
        1: pct = 100;
        2: pct = 50;
        3: pct = 25;
        default: pct = 10;
      endcase
      steady_flow = ($urandom_range(0, 6) == 0);
      send_random_map(cells, pct);
      sent += cells;
      maps++;
    end
    steady_flow = 1'b0;
  endtask

  // Result side: random stalls, some long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        res_if.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b0;
        stall_left <= pick_gap();
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Compare each result with the oldest expected square
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_squares.size() == 0) begin
        note_mismatch($sformatf("unexpected result: size %0d row %0d col %0d",
                                res_if.best_size, res_if.best_row, res_if.best_col));
      end else begin
        oldest_square = expected_squares.pop_front();
        if (res_if.best_size !== oldest_square.size)
          note_mismatch($sformatf("best_size expected %0d got %0d",
                                  oldest_square.size, res_if.best_size));
        if (res_if.best_row !== oldest_square.row)
          note_mismatch($sformatf("best_row expected %0d got %0d",
                                  oldest_square.row, res_if.best_row));
        if (res_if.best_col !== oldest_square.col)
          note_mismatch($sformatf("best_col expected %0d got %0d",
                                  oldest_square.col, res_if.best_col));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    cell_if.valid = 1'b0;
    cell_if.cell_req = '0;
    cell_if.end_of_map = 1'b0;
    res_if.ready = 1'b0;
    line_width_cfg = WidthReset;
    foreach (prev_row_sizes[i]) prev_row_sizes[i] = '0;
    clear_scan();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_width();
    test_no_square();
    test_ties();
    test_width_limits();
    test_char_extremes();
    test_tall_map();
    test_full_width();
    test_random_maps();

    // drain
    cell_if.valid <= 1'b0;
    while (expected_squares.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
